// File: sv/skf_pkg.sv
// skf_pkg: shared constants and codes for the scalar kalman filter
// no dependencies; used by scalar_kalman_filter
`default_nettype none

package skf_pkg;

    // fixed point format of estimate and variance values
    localparam int FRAC_BITS = 16;
    localparam int GAIN_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = GAIN_BITS + 1;
    localparam int CNT_W     = $clog2(GAIN_BITS + 1);

    // stream word widths
    localparam int OUT_BITS  = 2 * DATA_W + GAIN_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    // reset values of the configuration registers
    localparam longint ONE_FIX = longint'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] PROCESS_NOISE_RST     = DATA_W'((ONE_FIX + 500) / 1000);
    localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RST = DATA_W'((ONE_FIX + 5) / 10);
    localparam logic [DATA_W-1:0] START_VARIANCE_RST    = DATA_W'(ONE_FIX);
    localparam logic [DATA_W-1:0] START_ESTIMATE_RST    = '0;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

    typedef enum logic [1:0] {
        CFG_PROCESS_NOISE     = 2'd0,
        CFG_MEASUREMENT_NOISE = 2'd1,
        CFG_START_VARIANCE    = 2'd2,
        CFG_START_ESTIMATE    = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        CMD_SAMPLE  = 1'b0,
        CMD_RESTART = 1'b1
    } cmd_t;

endpackage

`default_nettype wire

// File: sv/scalar_kalman_filter.sv
// scalar_kalman_filter: one-dimensional fixed point kalman filter, bit-serial
// depends on skf_pkg
// a sample word passes through predict, sum, 17 restoring divide steps for the
// gain and 17 shift-add steps for both products, then waits in done until the
// output register is free; a restart word goes straight to done; a new word is
// taken only in idle, after the last result has moved to the output register;
// the output register lets a new word in while a result waits
// rst_n clears control state and loads configuration and filter state defaults
`default_nettype none

module scalar_kalman_filter (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [skf_pkg::DATA_W-1:0]  s_tdata,   // [31:0] sample
    input  wire logic                        s_tuser,   // [0] cmd
    // output stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [skf_pkg::OUT_W-1:0]        m_tdata,   // [31:0] estimate,
                                                        // [63:32] error_variance,
                                                        // [80:64] gain, rest zero
    // configuration writes
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [skf_pkg::DATA_W-1:0]  cfg_data
);

    localparam int DW = skf_pkg::DATA_W;
    localparam int GW = skf_pkg::GAIN_W;
    localparam int CW = skf_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_SUM,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

    state_t               state_reg,   state_next;
    logic [CW-1:0]        cnt_reg,     cnt_next;

    logic [DW-1:0]        q_noise_reg, q_noise_next;
    logic [DW-1:0]        r_noise_reg, r_noise_next;
    logic [DW-1:0]        start_var_reg, start_var_next;
    logic [DW-1:0]        start_est_reg, start_est_next;

    logic [DW-1:0]        estimate_reg, estimate_next;
    logic [DW-1:0]        variance_reg, variance_next;

    logic [DW-1:0]        sample_reg,  sample_next;
    logic [DW-1:0]        p_reg,       p_next;
    logic [DW:0]          sum_reg,     sum_next;
    logic [DW+1:0]        rem_reg,     rem_next;
    logic [GW-1:0]        q_reg,       q_next;
    logic [GW-1:0]        gain_reg,    gain_next;
    logic signed [DW:0]   diff_reg,    diff_next;
    logic signed [DW+1:0] acc_e_reg,   acc_e_next;
    logic [DW:0]          acc_v_reg,   acc_v_next;
    logic [GW-1:0]        mb_e_reg,    mb_e_next;
    logic [GW-1:0]        mb_v_reg,    mb_v_next;

    logic [DW-1:0]        res_est_reg, res_est_next;
    logic [DW-1:0]        res_var_reg, res_var_next;
    logic [GW-1:0]        res_gain_reg, res_gain_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [skf_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;

    // datapath terms
    logic [DW:0]          pred_sum;
    logic [DW+2:0]        div_trial;
    logic                 div_ge;
    logic [DW+1:0]        div_rem;
    logic [GW-1:0]        q_shift;
    logic [GW-1:0]        gain_calc;
    logic signed [DW+1:0] mul_add_e;
    logic [DW:0]          mul_add_v;
    logic                 last_step;
    logic                 out_free;

    assign pred_sum  = {1'b0, variance_reg} + {1'b0, q_noise_reg};
    assign div_trial = {1'b0, rem_reg} - {2'b00, sum_reg};
    assign div_ge    = ~div_trial[DW+2];
    assign div_rem   = div_ge ? div_trial[DW+1:0] : rem_reg;
    assign q_shift   = {q_reg[GW-2:0], div_ge};
    // zero denominator gives zero gain
    assign gain_calc = (sum_reg == '0) ? '0 : q_shift;
    assign mul_add_e = acc_e_reg + (mb_e_reg[0] ? {diff_reg[DW], diff_reg} : '0);
    assign mul_add_v = acc_v_reg + (mb_v_reg[0] ? {1'b0, p_reg} : '0);
    assign last_step = (cnt_reg == CW'(skf_pkg::GAIN_BITS));
    assign out_free  = ~m_tvalid_reg | m_tready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        q_noise_next   = q_noise_reg;
        r_noise_next   = r_noise_reg;
        start_var_next = start_var_reg;
        start_est_next = start_est_reg;
        estimate_next  = estimate_reg;
        variance_next  = variance_reg;
        sample_next    = sample_reg;
        p_next         = p_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        gain_next      = gain_reg;
        diff_next      = diff_reg;
        acc_e_next     = acc_e_reg;
        acc_v_next     = acc_v_reg;
        mb_e_next      = mb_e_reg;
        mb_v_next      = mb_v_reg;
        res_est_next   = res_est_reg;
        res_var_next   = res_var_reg;
        res_gain_next  = res_gain_reg;
        m_tvalid_next  = m_tvalid_reg & ~m_tready;
        m_tdata_next   = m_tdata_reg;

        if (cfg_valid)
        begin
            case (skf_pkg::cfg_reg_t'(cfg_index))
                skf_pkg::CFG_PROCESS_NOISE:     q_noise_next   = cfg_data;
                skf_pkg::CFG_MEASUREMENT_NOISE: r_noise_next   = cfg_data;
                skf_pkg::CFG_START_VARIANCE:    start_var_next = cfg_data;
                skf_pkg::CFG_START_ESTIMATE:    start_est_next = cfg_data;
                default:                        q_noise_next   = q_noise_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (skf_pkg::cmd_t'(s_tuser) == skf_pkg::CMD_RESTART)
                    begin
                        res_est_next  = start_est_reg;
                        res_var_next  = start_var_reg;
                        res_gain_next = '0;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        sample_next = s_tdata;
                        state_next  = ST_PRED;
                    end
                end
            end
            ST_PRED:
            begin
                // predicted variance saturates at all ones
                p_next     = pred_sum[DW] ? '1 : pred_sum[DW-1:0];
                diff_next  = $signed({sample_reg[DW-1], sample_reg})
                           - $signed({estimate_reg[DW-1], estimate_reg});
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                sum_next   = {1'b0, p_reg} + {1'b0, r_noise_reg};
                rem_next   = {2'b00, p_reg};
                q_next     = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit per cycle, msb first
                rem_next = {div_rem[DW:0], 1'b0};
                q_next   = q_shift;
                cnt_next = cnt_reg + CW'(1);
                if (last_step)
                begin
                    gain_next  = gain_calc;
                    mb_e_next  = gain_calc;
                    mb_v_next  = skf_pkg::GAIN_ONE - gain_calc;
                    acc_e_next = '0;
                    acc_v_next = '0;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // shift-add multiply, lsb first; dropped bits give the floor
                mb_e_next = mb_e_reg >> 1;
                mb_v_next = mb_v_reg >> 1;
                cnt_next  = cnt_reg + CW'(1);
                if (last_step)
                begin
                    res_est_next  = estimate_reg + mul_add_e[DW-1:0];
                    res_var_next  = mul_add_v[DW-1:0];
                    res_gain_next = gain_reg;
                    state_next    = ST_DONE;
                end
                else
                begin
                    acc_e_next = {mul_add_e[DW+1], mul_add_e[DW+1:1]};
                    acc_v_next = {1'b0, mul_add_v[DW:1]};
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    estimate_next = res_est_reg;
                    variance_next = res_var_reg;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = skf_pkg::OUT_W'({res_gain_reg, res_var_reg, res_est_reg});
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            q_noise_reg   <= skf_pkg::PROCESS_NOISE_RST;
            r_noise_reg   <= skf_pkg::MEASUREMENT_NOISE_RST;
            start_var_reg <= skf_pkg::START_VARIANCE_RST;
            start_est_reg <= skf_pkg::START_ESTIMATE_RST;
            estimate_reg  <= skf_pkg::START_ESTIMATE_RST;
            variance_reg  <= skf_pkg::START_VARIANCE_RST;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            q_noise_reg   <= q_noise_next;
            r_noise_reg   <= r_noise_next;
            start_var_reg <= start_var_next;
            start_est_reg <= start_est_next;
            estimate_reg  <= estimate_next;
            variance_reg  <= variance_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        p_reg        <= p_next;
        sum_reg      <= sum_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        gain_reg     <= gain_next;
        diff_reg     <= diff_next;
        acc_e_reg    <= acc_e_next;
        acc_v_reg    <= acc_v_next;
        mb_e_reg     <= mb_e_next;
        mb_v_reg     <= mb_v_next;
        res_est_reg  <= res_est_next;
        res_var_reg  <= res_var_next;
        res_gain_reg <= res_gain_next;
        m_tdata_reg  <= m_tdata_next;
    end

endmodule

`default_nettype wire
